>>> hdl/kcc_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// kcc_pkg
// Shared types and constants of the k-means color cluster pass.
// -----------------------------------------------------------------------------
package kcc_pkg;

  localparam int MAX_COLORS_DEF = 16;
  localparam int COUNT_BITS_DEF = 24;
  localparam int RESULT_LIMIT   = 16;

  localparam logic [4:0] ACTIVE_RESET = 5'd16;

  localparam logic OP_SEED       = 1'b0;
  localparam logic OP_PIXEL      = 1'b1;
  localparam logic KIND_LABEL    = 1'b0;
  localparam logic KIND_CENTROID = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ACC_RD,
    S_ACC_WR,
    S_UPD_RD,
    S_UPD_DIV,
    S_UPD_WAIT,
    S_UPD_EMIT
  } state_t;

  // tag that travels with a centroid read through the distance pipe
  typedef struct packed {
    logic v;
    logic first;
    logic last;
  } scan_tag_t;

endpackage
`default_nettype wire

>>> hdl/kcc_divider.sv
`default_nettype none
// -----------------------------------------------------------------------------
// kcc_divider
// Four-lane restoring divider: (sum << 8) / count, capped at 0xFFFF.
// -----------------------------------------------------------------------------
module kcc_divider #(
  parameter int COUNT_BITS = kcc_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [127:0]          sums,
  input  logic [COUNT_BITS-1:0] count,
  output logic                  done,
  output logic [63:0]           quot
);
  import kcc_pkg::*;

  localparam int RW = COUNT_BITS + 1;

  logic                  busy;
  logic [3:0]            step;
  logic [COUNT_BITS-1:0] cnt;
  logic [RW-1:0]         rem   [4];
  logic [15:0]           lo    [4];
  logic [15:0]           qv    [4];
  logic [3:0]            cap;
  logic [RW-1:0]         trial [4];
  logic [3:0]            ge;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      trial[j] = {rem[j][RW-2:0], lo[j][15]};
      ge[j]    = trial[j] >= {1'b0, cnt};
      quot[16*j +: 16] = cap[j] ? 16'hFFFF : qv[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == 4'd15);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 4'd1;
        if (step == 4'd15) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= count;
      for (int j = 0; j < 4; j++) begin
        cap[j] <= 40'(sums[32*j +: 32]) >= 40'({count, 8'h00});
        rem[j] <= RW'(sums[32*j+8 +: 24]);
        lo[j]  <= {sums[32*j +: 8], 8'h00};
        qv[j]  <= '0;
      end
    end else if (busy) begin
      for (int j = 0; j < 4; j++) begin
        rem[j] <= ge[j] ? trial[j] - {1'b0, cnt} : trial[j];
        lo[j]  <= {lo[j][14:0], 1'b0};
        qv[j]  <= {qv[j][14:0], ge[j]};
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/kcc_nearest.sv
`default_nettype none
// -----------------------------------------------------------------------------
// kcc_nearest
// Two-stage squared-distance pipe with a running minimum over centroids.
// -----------------------------------------------------------------------------
module kcc_nearest #(
  parameter int IDX_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  kcc_pkg::scan_tag_t tag,
  input  logic [IDX_W-1:0]  idx,
  input  logic [63:0]       cen,
  input  logic [31:0]       pix,
  output logic              done,
  output logic [IDX_W-1:0]  best
);
  import kcc_pkg::*;

  logic [16:0]      diff [4];
  logic [15:0]      mag  [4];
  logic [31:0]      sq   [4];
  scan_tag_t        s1_tag;
  logic [IDX_W-1:0] s1_idx;
  logic [33:0]      d_sum;
  logic [33:0]      best_d;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      diff[j] = {1'b0, pix[8*j +: 8], 8'h00} - {1'b0, cen[16*j +: 16]};
      mag[j]  = diff[j][16] ? 16'(-diff[j]) : diff[j][15:0];
    end
    d_sum = 34'(sq[0]) + 34'(sq[1]) + 34'(sq[2]) + 34'(sq[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
      done   <= 1'b0;
    end else begin
      s1_tag <= tag;
      done   <= s1_tag.v && s1_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= idx;
    for (int j = 0; j < 4; j++) sq[j] <= mag[j] * mag[j];
    // strict less keeps the lower index on a tie
    if (s1_tag.v && (s1_tag.first || d_sum < best_d)) begin
      best_d <= d_sum;
      best   <= s1_idx;
    end
  end

endmodule
`default_nettype wire

>>> hdl/kmeans_color_cluster_pass_core.sv
`default_nettype none
// -----------------------------------------------------------------------------
// kmeans_color_cluster_pass_core
// One Lloyd pass of k-means color clustering over RGBA pixels.
// -----------------------------------------------------------------------------
// Items: tuser selects seed (0) or pixel (1); tlast marks the last pixel of a
// pass. A seed writes one centroid and produces nothing. A pixel is compared
// against the active centroids, one centroid memory read per cycle, through a
// two-stage distance pipe; the input is held off until its label leaves. The
// label carries the centroid as it stood before the pixel. The pixel then
// updates its cluster's sums and count in the accumulator memory (read,
// modify, write). On a pass end each active centroid is read back and, if its
// cluster has members, replaced by sum*256/count from a four-lane divider.
// Results leave through a one-item output register, so a full output only
// stalls the sequencer at the point where it emits. Sums and counts are
// cleared by dropping one valid bit per cluster, so no clearing pass is needed.
// active_colors may only be written while the block is idle.
// -----------------------------------------------------------------------------
module kmeans_color_cluster_pass_core #(
  parameter int MAX_COLORS = kcc_pkg::MAX_COLORS_DEF,
  parameter int COUNT_BITS = kcc_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // slot[3:0], pix_red[11:4], pix_green[19:12], pix_blue[27:20],
  // pix_alpha[35:28], zero pad
  input  logic [39:0] s_tdata,
  input  logic        s_tuser,   // operation
  input  logic        s_tlast,   // pass_end
  output logic        m_tvalid,
  input  logic        m_tready,
  // cluster[3:0], out_red[19:4], out_green[35:20], out_blue[51:36],
  // out_alpha[67:52], zero pad
  output logic [71:0] m_tdata,
  output logic        m_tuser,   // result_kind
  output logic        m_tlast,   // final_item
  input  logic        cfg_we,
  input  logic [4:0]  cfg_data   // active_colors
);
  import kcc_pkg::*;

  localparam int IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int LIM   = (MAX_COLORS < RESULT_LIMIT) ? MAX_COLORS : RESULT_LIMIT;
  localparam int ROW_W = 128 + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // configuration
  logic [4:0] active;
  logic [4:0] n_eff;

  always_ff @(posedge clk) begin
    if (rst) active <= ACTIVE_RESET;
    else if (cfg_we) active <= cfg_data;
  end

  always_comb begin
    n_eff = active;
    if (n_eff == 5'd0) n_eff = 5'd1;
    if (32'(n_eff) > LIM) n_eff = 5'(LIM);
  end

  // sequencer state
  state_t           state, state_next;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] scan_idx;
  logic             issuing;
  logic [IDX_W-1:0] upd_idx;
  logic [31:0]      pix;
  logic             pass_end;
  logic [63:0]      new_c;

  // memories and their read ports
  logic [63:0]      cen_mem [MAX_COLORS];
  logic [ROW_W-1:0] acc_mem [MAX_COLORS];
  logic [MAX_COLORS-1:0] cen_vld, acc_vld;
  logic [IDX_W-1:0] cen_addr, acc_addr;
  logic [63:0]      cen_q, cen_m;
  logic [ROW_W-1:0] acc_q, row;
  logic             cen_vq, acc_vq;
  logic             cen_we;
  logic [IDX_W-1:0] cen_waddr;
  logic [63:0]      cen_wdata;
  logic             acc_we;
  logic [ROW_W-1:0] acc_wdata;

  // distance pipe
  scan_tag_t        rd_tag;
  logic [IDX_W-1:0] rd_idx;
  logic             near_done;
  logic [IDX_W-1:0] best;

  // divider
  logic             div_start, div_done;
  logic [63:0]      div_q;

  // output register
  logic             out_valid, out_free, out_load;
  logic             out_kind, out_last;
  logic [3:0]       out_idx;
  logic [63:0]      out_c;
  logic             ld_kind, ld_last;
  logic [IDX_W-1:0] ld_idx;
  logic [63:0]      ld_c;

  // control strobes
  logic             accept, seed_wr, pix_take, acc_upd, emit_cen;
  logic             cen_has_members;
  logic [COUNT_BITS-1:0] row_cnt;
  logic [ROW_W-1:0] row_next;
  logic [32:0]      sum_add [4];

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign seed_wr  = accept && (s_tuser == OP_SEED) && (32'(s_tdata[3:0]) < MAX_COLORS);
  assign pix_take = accept && (s_tuser == OP_PIXEL);

  assign cen_addr = (state == S_SCAN) ? scan_idx :
                    ((state == S_ACC_RD || state == S_ACC_WR) ? best : upd_idx);
  assign acc_addr = (state == S_ACC_RD || state == S_ACC_WR) ? best : upd_idx;

  // a never-written entry reads as zero
  assign cen_m   = cen_vq ? cen_q : '0;
  assign row     = acc_vq ? acc_q : '0;
  assign row_cnt = row[ROW_W-1 -: COUNT_BITS];
  assign cen_has_members = row_cnt != '0;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sum_add[j] = {1'b0, row[32*j +: 32]} + 33'(pix[8*j +: 8]);
      row_next[32*j +: 32] = sum_add[j][32] ? 32'hFFFF_FFFF : sum_add[j][31:0];
    end
    row_next[ROW_W-1 -: COUNT_BITS] = row_cnt + COUNT_BITS'(1);
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    acc_upd    = 1'b0;
    emit_cen   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    ld_kind    = KIND_LABEL;
    ld_idx     = best;
    ld_c       = cen_m;
    ld_last    = 1'b1;
    case (state)
      S_IDLE: begin
        if (pix_take) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (near_done) state_next = S_ACC_RD;
      end
      S_ACC_RD: state_next = S_ACC_WR;
      S_ACC_WR: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_last    = !pass_end;
          acc_upd    = row_cnt < CNT_MAX;
          state_next = pass_end ? S_UPD_RD : S_IDLE;
        end
      end
      S_UPD_RD: state_next = S_UPD_DIV;
      S_UPD_DIV: begin
        div_start  = cen_has_members;
        state_next = cen_has_members ? S_UPD_WAIT : S_UPD_EMIT;
      end
      S_UPD_WAIT: begin
        if (div_done) state_next = S_UPD_EMIT;
      end
      S_UPD_EMIT: begin
        ld_kind = KIND_CENTROID;
        ld_idx  = upd_idx;
        ld_c    = new_c;
        ld_last = (upd_idx == last_idx);
        if (out_free) begin
          out_load   = 1'b1;
          emit_cen   = 1'b1;
          state_next = (upd_idx == last_idx) ? S_IDLE : S_UPD_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // memory write ports
  assign cen_we    = seed_wr || emit_cen;
  assign cen_waddr = emit_cen ? upd_idx : IDX_W'(s_tdata[3:0]);
  assign cen_wdata = emit_cen ? new_c :
                     {s_tdata[35:28], 8'h00, s_tdata[27:20], 8'h00,
                      s_tdata[19:12], 8'h00, s_tdata[11:4], 8'h00};
  assign acc_we    = acc_upd;
  assign acc_wdata = row_next;

  always_ff @(posedge clk) begin
    if (cen_we) cen_mem[cen_waddr] <= cen_wdata;
    cen_q <= cen_mem[cen_addr];
    if (acc_we) acc_mem[best] <= acc_wdata;
    acc_q <= acc_mem[acc_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cen_vld <= '0;
      acc_vld <= '0;
      cen_vq  <= 1'b0;
      acc_vq  <= 1'b0;
    end else begin
      cen_vq <= cen_vld[cen_addr];
      acc_vq <= acc_vld[acc_addr];
      if (cen_we) cen_vld[cen_waddr] <= 1'b1;
      if (acc_upd) acc_vld[best] <= 1'b1;
      // last centroid of the pass drops every sum and count
      if (emit_cen && upd_idx == last_idx) acc_vld <= '0;
    end
  end

  // scan issue: one centroid read per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      rd_tag  <= '0;
    end else begin
      rd_tag.v     <= (state == S_SCAN) && issuing;
      rd_tag.first <= (scan_idx == '0);
      rd_tag.last  <= (scan_idx == last_idx);
      if (pix_take) issuing <= 1'b1;
      else if (state == S_SCAN && issuing && scan_idx == last_idx) issuing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
    if (pix_take) begin
      scan_idx <= '0;
      last_idx <= IDX_W'(n_eff - 5'd1);
      pix      <= s_tdata[35:4];
      pass_end <= s_tlast;
    end else if (state == S_SCAN && issuing) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (state == S_ACC_WR) upd_idx <= '0;
    else if (emit_cen) upd_idx <= upd_idx + IDX_W'(1);
    if (state == S_UPD_DIV && !cen_has_members) new_c <= cen_m;
    else if (state == S_UPD_WAIT && div_done) new_c <= div_q;
  end

  kcc_nearest #(
    .IDX_W (IDX_W)
  ) u_nearest (
    .clk  (clk),
    .rst  (rst),
    .tag  (rd_tag),
    .idx  (rd_idx),
    .cen  (cen_m),
    .pix  (pix),
    .done (near_done),
    .best (best)
  );

  kcc_divider #(
    .COUNT_BITS (COUNT_BITS)
  ) u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sums  (row[127:0]),
    .count (row_cnt),
    .done  (div_done),
    .quot  (div_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= 1'b1;
    else if (m_tready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind <= ld_kind;
      out_idx  <= 4'(ld_idx);
      out_c    <= ld_c;
      out_last <= ld_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {4'h0, out_c, out_idx};

endmodule
`default_nettype wire

>>> hdl/kcc_checker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// kcc_checker
// Port-level checks of the cluster pass core, bound to the top level.
// -----------------------------------------------------------------------------
module kcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  // output item holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output item dropped or changed under stall");

  // reset leaves no result pending and the input open
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  // a pixel occupies the sequencer: no new item next cycle
  a_pixel_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input taken while a pixel is in flight");

endmodule

bind kmeans_color_cluster_pass_core kcc_checker u_kcc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

>>> verif/testbench.sv
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the k-means color cluster pass core: seeds, labelled
// pixels and pass-end centroid updates are predicted in a scoreboard class and
// compared field by field against the output stream under random idling.
// -----------------------------------------------------------------------------
module testbench;
  import kcc_pkg::*;

  localparam int NCOL      = 16;
  localparam int CNT_MAX   = (1 << 24) - 1;
  localparam int LIMIT_CYC = 1000000;

  // one result item as seen on the master side
  typedef struct packed {
    logic        kind;
    logic [3:0]  cluster;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic        final_item;
  } palette_out_t;

  // palette model: centroids, running sums and counts
  class palette_scoreboard;
    logic [15:0] cent [NCOL][4];
    logic [31:0] sums [NCOL][4];
    int unsigned counts [NCOL];
    int unsigned n_active;
    palette_out_t pending [$];
    int mismatches;

    function void reset_model();
      foreach (cent[i, j]) begin
        cent[i][j] = '0;
        sums[i][j] = '0;
      end
      foreach (counts[i]) counts[i] = 0;
      n_active = 16;
      mismatches = 0;
    endfunction

    function void set_active(logic [4:0] v);
      n_active = v;
    endfunction

    function palette_out_t make_out(logic kind, int idx, logic fin);
      palette_out_t o;
      o.kind = kind;
      o.cluster = idx[3:0];
      o.red = cent[idx][0];
      o.green = cent[idx][1];
      o.blue = cent[idx][2];
      o.alpha = cent[idx][3];
      o.final_item = fin;
      return o;
    endfunction

    // note one accepted input item
    function void note_input(logic op, logic [3:0] slot, logic [7:0] ch [4], logic pe);
      int n, best;
      longint unsigned d, best_d;
      longint signed df;
      longint unsigned q;
      logic [32:0] s;
      if (op == OP_SEED) begin
        for (int j = 0; j < 4; j++) cent[slot][j] = {ch[j], 8'h00};
        return;
      end
      n = (n_active < 1) ? 1 : (n_active > NCOL ? NCOL : n_active);
      best = 0;
      best_d = 0;
      for (int i = 0; i < n; i++) begin
        d = 0;
        for (int j = 0; j < 4; j++) begin
          df = longint'({ch[j], 8'h00}) - longint'(cent[i][j]);
          d += df * df;
        end
        if (i == 0 || d < best_d) begin
          best_d = d;
          best = i;
        end
      end
      pending.push_back(make_out(KIND_LABEL, best, !pe));
      if (counts[best] < CNT_MAX) begin
        counts[best]++;
        for (int j = 0; j < 4; j++) begin
          s = {1'b0, sums[best][j]} + ch[j];
          sums[best][j] = s[32] ? 32'hFFFF_FFFF : s[31:0];
        end
      end
      if (!pe) return;
      for (int i = 0; i < n; i++) begin
        if (counts[i] != 0)
          for (int j = 0; j < 4; j++) begin
            q = ({32'd0, sums[i][j]} << 8) / counts[i];
            cent[i][j] = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
          end
        pending.push_back(make_out(KIND_CENTROID, i, i == n - 1));
      end
      foreach (counts[i]) begin
        counts[i] = 0;
        for (int j = 0; j < 4; j++) sums[i][j] = '0;
      end
    endfunction

    // check one accepted result against the oldest expectation
    function void check_result(palette_out_t got);
      palette_out_t exp_o;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_o = pending.pop_front();
      if (got !== exp_o) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: kind %0d/%0d cl %0d/%0d r %h/%h g %h/%h b %h/%h a %h/%h f %0d/%0d",
                   exp_o.kind, got.kind, exp_o.cluster, got.cluster, exp_o.red, got.red,
                   exp_o.green, got.green, exp_o.blue, got.blue, exp_o.alpha, got.alpha,
                   exp_o.final_item, got.final_item);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_data = '0;

  palette_scoreboard sb = new();
  int send_idle_pct = 0;      // sender idle chance, percent
  int recv_idle_pct = 0;      // receiver stall chance, percent
  int cycles = 0;

  kmeans_color_cluster_pass_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, check on each handshake
  always @(posedge clk) begin
    palette_out_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser;
      got.cluster = m_tdata[3:0];
      got.red = m_tdata[19:4];
      got.green = m_tdata[35:20];
      got.blue = m_tdata[51:36];
      got.alpha = m_tdata[67:52];
      got.final_item = m_tlast;
      sb.check_result(got);
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // send one item, holding valid until accepted; valid stays up after the
  // handshake so a following item can go back to back, callers drop it
  task automatic send_item(logic op, logic [3:0] slot, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b, logic [7:0] a, logic pe);
    logic [7:0] ch [4];
    ch[0] = r; ch[1] = g; ch[2] = b; ch[3] = a;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tlast <= pe;
    s_tdata <= {4'h0, a, b, g, r, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(op, slot, ch, pe);
  endtask

  // wait for all results, then let the block settle before a register write
  task automatic drain_and_set(logic [4:0] v);
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_active(v);
  endtask

  task automatic random_pixel(logic pe);
    send_item(OP_PIXEL, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), pe);
  endtask

  // a well-formed pass: a few seeds, pixels, then a pass end
  task automatic random_pass(int n_pix);
    for (int i = 0; i < $urandom_range(3); i++)
      send_item(OP_SEED, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 1'($urandom));
    for (int i = 0; i < n_pix; i++) random_pixel(1'b0);
    random_pixel(1'b1);
  endtask

  initial begin
    int sent;
    logic [4:0] settings [6];
    sb.reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: seed extremes, ties, empty clusters, pass ends
    send_item(OP_SEED, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_item(OP_SEED, 4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_item(OP_SEED, 4'd1, 8'h80, 8'h80, 8'h80, 8'h80, 1'b0);
    send_item(OP_PIXEL, 4'd15, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);   // tie over zero slots
    send_item(OP_PIXEL, 4'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_item(OP_PIXEL, 4'd5, 8'h40, 8'h40, 8'h40, 8'h40, 1'b0);    // equidistant 0 and 1
    send_item(OP_PIXEL, 4'd0, 8'h81, 8'h7F, 8'h01, 8'hFE, 1'b0);
    send_item(OP_PIXEL, 4'd0, 8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1);    // pass end, empty clusters kept
    send_item(OP_PIXEL, 4'd0, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1);    // pass end of one pixel
    drain_and_set(5'd1);
    send_item(OP_PIXEL, 4'd0, 8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
    send_item(OP_PIXEL, 4'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    drain_and_set(5'd0);                                              // zero acts as one
    send_item(OP_PIXEL, 4'd3, 8'h01, 8'h02, 8'h03, 8'h04, 1'b1);
    drain_and_set(5'd31);                                             // above range, acts as 16
    send_item(OP_SEED, 4'd7, 8'h10, 8'h20, 8'h30, 8'h40, 1'b0);
    send_item(OP_PIXEL, 4'd0, 8'h10, 8'h20, 8'h30, 8'h41, 1'b0);
    send_item(OP_PIXEL, 4'd0, 8'h11, 8'h20, 8'h30, 8'h40, 1'b1);
    drain_and_set(5'd16);

    // random: mostly passes, some loose pixels and seeds
    settings = '{5'd2, 5'd16, 5'd7, 5'd1, 5'd16, 5'd4};
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 38; recv_idle_pct = 76;
      end else if (ph < 4) begin
        send_idle_pct = 76; recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      drain_and_set(settings[ph]);
      while (sent < 37 * (ph + 1)) begin
        if ($urandom_range(9) < 8) begin
          random_pass($urandom_range(1, 8));
          sent += 6;
        end else if ($urandom_range(1)) begin
          random_pixel(1'($urandom));
          sent++;
        end else begin
          send_item(OP_SEED, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 1'($urandom));
          sent++;
        end
      end
    end

    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end
endmodule
